@@ sv/lmag_pkg.sv @@
// ----------------------------------------------------------------------------
// lmag_pkg
// shared constants and types for the level moving average gauge
// ----------------------------------------------------------------------------
package lmag_pkg;

    localparam int LEVEL_W = 16;     // sample, average and full scale width
    localparam int GRAD_W  = 3;      // graduation width
    localparam int PROD_W  = 23;     // holds 65535 * 100

    localparam int PCT_SCALE  = 100; // percent of full scale
    localparam int PCT_STEP   = 17;  // percent per graduation step
    localparam int GRAD_MAX   = 6;   // graduation cap
    localparam int GRAD_STEPS = GRAD_MAX - 1;

    localparam logic [LEVEL_W-1:0] FULL_SCALE_RESET = LEVEL_W'(1200);

    // divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

@@ sv/lmag_ring.sv @@
// ----------------------------------------------------------------------------
// lmag_ring
// sample ring memory, one port, read-before-write, registered read data
// ----------------------------------------------------------------------------
module lmag_ring #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = 4
) (
    input  logic                         aclk,
    input  logic                         access,
    input  logic [ADDR_W-1:0]            addr,
    input  logic [lmag_pkg::LEVEL_W-1:0] wr_data,
    output logic [lmag_pkg::LEVEL_W-1:0] rd_data
);

    logic [lmag_pkg::LEVEL_W-1:0] mem [DEPTH];
    logic [lmag_pkg::LEVEL_W-1:0] rd_data_reg;

    // old entry comes out while the new sample goes in
    always_ff @(posedge aclk) begin
        if (access) begin
            rd_data_reg <= mem[addr];
            mem[addr]   <= wr_data;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ sv/lmag_div.sv @@
// ----------------------------------------------------------------------------
// lmag_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lmag_div #(
    parameter int DIVIDEND_W = 20,
    parameter int DIVISOR_W  = 5
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [DIVIDEND_W-1:0]       dividend,
    input  logic [DIVISOR_W-1:0]        divisor,
    output logic [DIVIDEND_W-1:0]       quotient,
    output lmag_pkg::div_status_t       status
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dvsr_reg, dvsr_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W:0]    shifted;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    always_comb begin
        shifted = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff    = shifted - {1'b0, dvsr_reg};
        fits    = !diff[DIVISOR_W];

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvsr_next = dvsr_reg;
        quo_next  = quo_reg;

        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            rem_next  = '0;
            dvsr_next = divisor;
            quo_next  = dividend;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvsr_reg <= dvsr_next;
        quo_reg  <= quo_next;
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    // a new division never lands on one in flight
    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        start |-> !busy_reg)
        else $error("divider started while busy");

    // done follows the last iteration exactly
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a running division");

    // counter stays live only while busy
    a_cnt_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> cnt_reg != '0)
        else $error("divider running with empty count");

endmodule

@@ sv/level_moving_average_gauge.sv @@
// ----------------------------------------------------------------------------
// level_moving_average_gauge
// moving average over the last WINDOW level samples with a six-step gauge
// ----------------------------------------------------------------------------
// One sample goes into a ring memory of WINDOW entries and a running total is
// kept next to it. Until the ring has filled, the average is the total over
// the number of samples so far; after that the oldest sample drops out and
// the total is divided by WINDOW. The graduation is floor(pct / 17) + 1 capped
// at 6, where pct = floor(average * 100 / full_scale_level), found by
// comparing average * 100 against multiples of full_scale_level * 17; a full
// scale of zero reads as graduation 6. After acceptance an item passes
// through the total update, the bit-serial divide and its done flag, the
// scaling and the grading, which waits until the output register is free;
// the ring read happens at the acceptance edge itself. The next item is
// taken as soon as the current one has left the pipeline into the output
// register, even if that result has not yet been taken, so only one item
// is in flight at a time. The configuration write port is always ready and
// must only be used while the block is idle.
// ----------------------------------------------------------------------------
module level_moving_average_gauge #(
    parameter int WINDOW = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration write
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [lmag_pkg::LEVEL_W-1:0] cfg_data,
    // sample items in
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [lmag_pkg::LEVEL_W-1:0] s_level_sample,
    // result items out
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [lmag_pkg::LEVEL_W-1:0] m_average_level,
    output logic [lmag_pkg::GRAD_W-1:0]  m_graduation,
    output logic                         m_window_full
);

    localparam int POS_W   = $clog2(WINDOW);
    localparam int CNT_W   = $clog2(WINDOW + 1);
    localparam int TOTAL_W = lmag_pkg::LEVEL_W + POS_W;
    localparam int PROD_W  = lmag_pkg::PROD_W;
    localparam int STEPS   = lmag_pkg::GRAD_STEPS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_DIV,
        ST_SCALE,
        ST_GRADE
    } state_t;

    state_t                       state_reg, state_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic                         filling_reg, filling_next;
    logic [TOTAL_W-1:0]           total_reg, total_next;
    logic [lmag_pkg::LEVEL_W-1:0] full_scale_reg, full_scale_next;

    // per-item working registers
    logic [lmag_pkg::LEVEL_W-1:0] sample_reg, sample_next;
    logic                         was_full_reg, was_full_next;
    logic [CNT_W-1:0]             count_reg, count_next;
    logic [lmag_pkg::LEVEL_W-1:0] avg_reg, avg_next;
    logic [PROD_W-1:0]            prod_reg, prod_next;
    logic [PROD_W-1:0]            thr_reg [STEPS];
    logic [PROD_W-1:0]            thr_next [STEPS];

    // output register
    logic                         m_valid_reg, m_valid_next;
    logic [lmag_pkg::LEVEL_W-1:0] m_avg_reg, m_avg_next;
    logic [lmag_pkg::GRAD_W-1:0]  m_grad_reg, m_grad_next;
    logic                         m_full_reg, m_full_next;

    logic                         in_fire;
    logic                         div_start;
    logic [lmag_pkg::LEVEL_W-1:0] old_sample;
    logic [TOTAL_W-1:0]           div_quotient;
    lmag_pkg::div_status_t        div_stat;
    logic [lmag_pkg::GRAD_W-1:0]  grad_calc;
    logic                         out_free;

    assign in_fire   = s_valid && s_ready;
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_valid_reg || m_ready;

    // ring: old entry read and new sample written at acceptance
    lmag_ring #(
        .DEPTH  (WINDOW),
        .ADDR_W (POS_W)
    ) u_ring (
        .aclk    (aclk),
        .access  (in_fire),
        .addr    (pos_reg),
        .wr_data (s_level_sample),
        .rd_data (old_sample)
    );

    // average divider: total over samples held
    lmag_div #(
        .DIVIDEND_W (TOTAL_W),
        .DIVISOR_W  (CNT_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (total_next),
        .divisor  (count_reg),
        .quotient (div_quotient),
        .status   (div_stat)
    );

    // graduation is one plus the number of step thresholds reached
    always_comb begin
        grad_calc = lmag_pkg::GRAD_W'(1);
        for (int k = 0; k < STEPS; k++) begin
            if (prod_reg >= thr_reg[k]) begin
                grad_calc = grad_calc + lmag_pkg::GRAD_W'(1);
            end
        end
    end

    always_comb begin
        state_next      = state_reg;
        pos_next        = pos_reg;
        filling_next    = filling_reg;
        total_next      = total_reg;
        full_scale_next = full_scale_reg;
        sample_next     = sample_reg;
        was_full_next   = was_full_reg;
        count_next      = count_reg;
        avg_next        = avg_reg;
        prod_next       = prod_reg;
        thr_next        = thr_reg;
        m_valid_next    = m_valid_reg;
        m_avg_next      = m_avg_reg;
        m_grad_next     = m_grad_reg;
        m_full_next     = m_full_reg;
        div_start       = 1'b0;

        if (cfg_valid && cfg_ready) begin
            full_scale_next = cfg_data;
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    sample_next   = s_level_sample;
                    was_full_next = !filling_reg;
                    // divisor is samples held after this one
                    count_next    = filling_reg ? CNT_W'(pos_reg) + CNT_W'(1)
                                                : CNT_W'(WINDOW);
                    if (pos_reg == POS_W'(WINDOW - 1)) begin
                        pos_next     = '0;
                        filling_next = 1'b0;
                    end else begin
                        pos_next = pos_reg + POS_W'(1);
                    end
                    state_next = ST_SUM;
                end
            end
            ST_SUM: begin
                // drop the evicted sample once the ring is full
                total_next = total_reg
                           - (was_full_reg ? TOTAL_W'(old_sample) : '0)
                           + TOTAL_W'(sample_reg);
                div_start  = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    avg_next   = div_quotient[lmag_pkg::LEVEL_W-1:0];
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                prod_next = PROD_W'(avg_reg * lmag_pkg::PCT_SCALE);
                for (int k = 0; k < STEPS; k++) begin
                    thr_next[k] = PROD_W'(full_scale_reg * (lmag_pkg::PCT_STEP * (k + 1)));
                end
                state_next = ST_GRADE;
            end
            ST_GRADE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_avg_next   = avg_reg;
                    m_grad_next  = grad_calc;
                    m_full_next  = !filling_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pos_reg        <= '0;
            filling_reg    <= 1'b1;
            total_reg      <= '0;
            full_scale_reg <= lmag_pkg::FULL_SCALE_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pos_reg        <= pos_next;
            filling_reg    <= filling_next;
            total_reg      <= total_next;
            full_scale_reg <= full_scale_next;
            m_valid_reg    <= m_valid_next;
        end
        sample_reg   <= sample_next;
        was_full_reg <= was_full_next;
        count_reg    <= count_next;
        avg_reg      <= avg_next;
        prod_reg     <= prod_next;
        thr_reg      <= thr_next;
        m_avg_reg    <= m_avg_next;
        m_grad_reg   <= m_grad_next;
        m_full_reg   <= m_full_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_average_level = m_avg_reg;
    assign m_graduation    = m_grad_reg;
    assign m_window_full   = m_full_reg;

    // one item in flight: no second acceptance right behind the first
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> !s_ready)
        else $error("item accepted while another is in flight");

    // divider is only busy while the sequencer waits on it
    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_stat.busy |-> state_reg == ST_DIV)
        else $error("divider busy outside the divide step");

    // graduation in the output register stays within one to six
    a_grad_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> m_grad_reg != '0
                     && m_grad_reg <= lmag_pkg::GRAD_W'(lmag_pkg::GRAD_MAX))
        else $error("graduation out of range");

    // once full, the ring never returns to filling
    a_full_sticks: assert property (@(posedge aclk) disable iff (!aresetn)
        !filling_reg |=> !filling_reg)
        else $error("ring fell back to filling");

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the level moving average gauge
// ----------------------------------------------------------------------------
// Level samples go in over a valid/ready channel. The sender works in bursts
// with random gaps, and the result side stalls in one of several patterns.
// A scoreboard keeps its own copy of the sample ring, the running total and
// the full scale setting. For every accepted item it computes the expected
// average, graduation and window-full flag, and it compares each result that
// comes out against the oldest expectation. The run starts with a short
// directed fill of the ring and then moves through phases. Each phase writes
// a new full scale value, with the extremes and zero among them, and then
// sends random level sequences around that scale.
// ----------------------------------------------------------------------------
module tb;

    localparam int          RING_DEPTH    = 16;
    localparam int          LEVEL_MAX     = 65535;
    localparam int unsigned QUIET_LIMIT   = 2000;
    localparam int          REPORT_LIMIT  = 10;
    localparam int          PHASE_COUNT   = 11;
    localparam int          DIRECTED_SIZE = 20;

    typedef struct packed {
        logic [lmag_pkg::LEVEL_W-1:0] average;
        logic [lmag_pkg::GRAD_W-1:0]  grad;
        logic                         full;
    } reading_t;

    typedef enum {RCV_ALWAYS, RCV_RANDOM, RCV_PATTERN} rcv_mode_e;

    // predicts each reading and holds the readings still to come
    class gauge_scoreboard;
        logic [lmag_pkg::LEVEL_W-1:0] ring [RING_DEPTH];
        int unsigned                  slot;
        bit                           filling;
        int unsigned                  total;
        logic [lmag_pkg::LEVEL_W-1:0] full_scale;
        reading_t                     expected_readings [$];
        int unsigned                  errors;
        int unsigned                  reports;

        function new();
            slot       = 0;
            filling    = 1'b1;
            total      = 0;
            full_scale = lmag_pkg::FULL_SCALE_RESET;
            errors     = 0;
            reports    = 0;
        endfunction

        function void set_full_scale(logic [lmag_pkg::LEVEL_W-1:0] value);
            full_scale = value;
        endfunction

        function int unsigned pending();
            return expected_readings.size();
        endfunction

        // takes one accepted sample and queues the reading it must cause
        function void note_sample(logic [lmag_pkg::LEVEL_W-1:0] level);
            reading_t    r;
            int unsigned avg;
            int unsigned steps;
            if (filling) begin
                ring[slot] = level;
                total += level;
                avg = total / (slot + 1);
            end else begin
                total -= ring[slot];
                ring[slot] = level;
                total += level;
                avg = total / RING_DEPTH;
            end
            slot++;
            if (slot == RING_DEPTH) begin
                slot    = 0;
                filling = 1'b0;
            end
            avg = avg & LEVEL_MAX;
            // zero full scale saturates to the top step
            if (full_scale == 0) begin
                steps = lmag_pkg::GRAD_MAX;
            end else begin
                steps = (avg * lmag_pkg::PCT_SCALE) / full_scale / lmag_pkg::PCT_STEP + 1;
                if (steps > lmag_pkg::GRAD_MAX) begin
                    steps = lmag_pkg::GRAD_MAX;
                end
            end
            r.average = avg[lmag_pkg::LEVEL_W-1:0];
            r.grad    = steps[lmag_pkg::GRAD_W-1:0];
            r.full    = !filling;
            expected_readings.push_back(r);
        endfunction

        function void check_result(reading_t got);
            reading_t want;
            if (expected_readings.size() == 0) begin
                errors++;
                if (reports < REPORT_LIMIT) begin
                    reports++;
                    $display("unexpected result: avg %0d grad %0d full %0d",
                             got.average, got.grad, got.full);
                end
                return;
            end
            want = expected_readings.pop_front();
            if (want.average !== got.average || want.grad !== got.grad ||
                want.full !== got.full) begin
                errors++;
                if (reports < REPORT_LIMIT) begin
                    reports++;
                    $display("mismatch: avg %0d/%0d grad %0d/%0d full %0d/%0d (exp/act)",
                             want.average, got.average, want.grad, got.grad,
                             want.full, got.full);
                end
            end
        endfunction
    endclass

    // clock, reset and block ports; the inputs driven here are known from time zero
    logic                         aclk           = 1'b0;
    logic                         aresetn        = 1'b0;
    logic                         cfg_valid      = 1'b0;
    logic                         cfg_ready;
    logic [lmag_pkg::LEVEL_W-1:0] cfg_data       = '0;
    logic                         s_valid        = 1'b0;
    logic                         s_ready;
    logic [lmag_pkg::LEVEL_W-1:0] s_level_sample = '0;
    logic                         m_valid;
    logic                         m_ready        = 1'b0;
    logic [lmag_pkg::LEVEL_W-1:0] m_average_level;
    logic [lmag_pkg::GRAD_W-1:0]  m_graduation;
    logic                         m_window_full;

    gauge_scoreboard sb;
    rcv_mode_e       rcv_mode    = RCV_ALWAYS;
    int unsigned     rcv_tick    = 0;
    int unsigned     quiet_cycles = 0;

    level_moving_average_gauge #(
        .WINDOW(RING_DEPTH)
    ) dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_level_sample (s_level_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_average_level(m_average_level),
        .m_graduation   (m_graduation),
        .m_window_full  (m_window_full)
    );

    always #4 aclk = ~aclk;

    // result side: stall pattern changes from phase to phase
    always @(negedge aclk) begin
        rcv_tick <= rcv_tick + 1;
        case (rcv_mode)
            RCV_ALWAYS: begin
                m_ready <= 1'b1;
            end
            RCV_RANDOM: begin
                m_ready <= ($urandom_range(0, 3) != 0);
            end
            default: begin
                // repeating pattern: ready, then stalled
                m_ready <= ((rcv_tick % 7) < 4);
            end
        endcase
    end

    // every accepted result is checked against the oldest expectation
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(reading_t'{m_average_level, m_graduation, m_window_full});
        end
    end

    // watchdog: too long without any handshake means the block hung
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // one sample item, after an optional gap with valid low;
    // valid is left high so a back-to-back item needs no lowering
    task automatic send_level(input logic [lmag_pkg::LEVEL_W-1:0] level,
                              input int unsigned gap);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_level_sample <= level;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(level);
        @(negedge aclk);
    endtask

    // full scale write, only once every pending reading has come out
    task automatic write_full_scale(input logic [lmag_pkg::LEVEL_W-1:0] value);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        sb.set_full_scale(value);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [lmag_pkg::LEVEL_W-1:0] directed_levels [DIRECTED_SIZE];
        logic [lmag_pkg::LEVEL_W-1:0] level;
        logic [lmag_pkg::LEVEL_W-1:0] scale;
        int unsigned                  top;
        int unsigned                  target;
        int unsigned                  jitter_sum;
        int unsigned                  burst_left;
        int unsigned                  gap;
        int unsigned                  phase_items;
        bit                           no_idle;

        // directed fill: extremes, zero average, step boundaries at 1200,
        // levels far above full scale; item 16 completes the ring
        directed_levels = '{
            16'd0,     16'd65535, 16'd65535, 16'd0,     16'd1200,
            16'd600,   16'd204,   16'd203,   16'd1199,  16'd1200,
            16'd2400,  16'd65535, 16'd65535, 16'd0,     16'd1,
            16'd32768, 16'd0,     16'd0,     16'd65535, 16'd5555
        };

        sb = new();
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed part runs at the reset full scale
        foreach (directed_levels[i]) begin
            send_level(directed_levels[i], $urandom_range(0, 3));
        end

        level      = '0;
        burst_left = 0;
        for (int p = 0; p < PHASE_COUNT; p++) begin
            // extremes, zero and the reset scale first, then random scales, half of them small
            case (p)
                0:       scale = 16'd65535;
                1:       scale = 16'd1;
                2:       scale = 16'd0;
                3:       scale = lmag_pkg::FULL_SCALE_RESET;
                default: scale = ($urandom_range(0, 1) != 0) ?
                                 lmag_pkg::LEVEL_W'($urandom_range(1, LEVEL_MAX)) :
                                 lmag_pkg::LEVEL_W'($urandom_range(1, 4000));
            endcase
            write_full_scale(scale);

            rcv_mode    = rcv_mode_e'($urandom_range(0, 2));
            no_idle     = ($urandom_range(0, 3) == 0);
            phase_items = $urandom_range(130, 170);
            top         = (scale == 0) ? LEVEL_MAX : scale + scale / 4;
            if (top > LEVEL_MAX) begin
                top = LEVEL_MAX;
            end
            target = $urandom_range(0, top);

            for (int n = 0; n < phase_items; n++) begin
                // held target levels let the average settle on every step
                if ($urandom_range(0, 19) == 0) begin
                    target = $urandom_range(0, top);
                end
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5, 6: begin
                        jitter_sum = target + $urandom_range(0, top / 8);
                        level = (jitter_sum > LEVEL_MAX) ?
                                lmag_pkg::LEVEL_W'(LEVEL_MAX) :
                                lmag_pkg::LEVEL_W'(jitter_sum);
                    end
                    7:       level = lmag_pkg::LEVEL_W'($urandom_range(0, LEVEL_MAX));
                    8:       level = ($urandom_range(0, 1) != 0) ? '1 : '0;
                    default: level = level;
                endcase

                // bursts of random length separated by random gaps
                gap = 0;
                if (!no_idle) begin
                    if (burst_left == 0) begin
                        gap        = $urandom_range(1, 40);
                        burst_left = $urandom_range(1, 24);
                    end
                    burst_left--;
                end
                send_level(level, gap);
            end
        end

        // drain, then give late or spurious results time to show up
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
